[rtl/core/risc_instruction_execute_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the RISC instruction execute block.
// Two forms: a same-cycle implication and a next-cycle implication.
// ---------------------------------------------------------------------------
`ifndef RISC_INSTRUCTION_EXECUTE_ASSERT_SVH
`define RISC_INSTRUCTION_EXECUTE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RIE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RIE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/rie_pkg.sv]
// ---------------------------------------------------------------------------
// rie_pkg
// Shared types and constants of the RISC instruction execute block.
// ---------------------------------------------------------------------------
package rie_pkg;

  // Fixed field widths.
  localparam int WORD_W    = 32;
  localparam int INSTR_W   = 20;
  localparam int PC_W      = 10;
  localparam int RIDX_W    = 4;
  localparam int REG_COUNT = 16;

  // Stream widths: instruction and immediate in, one result word out.
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 104;

  // Register indexes with a fixed role.
  localparam logic [RIDX_W-1:0] R0_IDX   = 4'd0;
  localparam logic [RIDX_W-1:0] R1_IDX   = 4'd1;
  localparam logic [RIDX_W-1:0] LINK_IDX = 4'd15;

  // I/O register that holds the interrupt return address.
  localparam int RETI_IO_IDX = 7;

  // Sign bit of the 20-bit immediate word.
  localparam int IMM_SIGN_BIT = 19;

  // Conditional subtract steps that reduce a 10-bit target modulo the
  // instruction memory size (at least 16 words, so the quotient is below 64).
  localparam int TGT_STEPS = 6;

  typedef enum logic [7:0] {
    OP_ADD  = 8'd0,
    OP_SUB  = 8'd1,
    OP_AND  = 8'd2,
    OP_OR   = 8'd3,
    OP_XOR  = 8'd4,
    OP_MUL  = 8'd5,
    OP_SLL  = 8'd6,
    OP_SRA  = 8'd7,
    OP_SRL  = 8'd8,
    OP_BEQ  = 8'd9,
    OP_BNE  = 8'd10,
    OP_BLT  = 8'd11,
    OP_BGT  = 8'd12,
    OP_BLE  = 8'd13,
    OP_BGE  = 8'd14,
    OP_JAL  = 8'd15,
    OP_LW   = 8'd16,
    OP_SW   = 8'd17,
    OP_RETI = 8'd18,
    OP_IN   = 8'd19,
    OP_OUT  = 8'd20,
    OP_HALT = 8'd21
  } op_e;

  // Result of the ALU: data value and branch condition.
  typedef struct packed {
    logic [WORD_W-1:0] val;
    logic              taken;
  } alu_out_t;

  // One result item; the last member sits in the lowest bits.
  typedef struct packed {
    logic [4:0]        io_index;
    logic              io_written;
    logic [WORD_W-1:0] store_value;
    logic [11:0]       mem_address;
    logic              mem_written;
    logic [WORD_W-1:0] written_value;
    logic [RIDX_W-1:0] written_reg;
    logic              reg_written;
    logic              used_immediate;
    logic              halted;
    logic [PC_W-1:0]   next_pc;
  } res_t;

  localparam int RES_W     = $bits(res_t);
  localparam int M_PAD_W   = M_TDATA_W - RES_W;

endpackage

[rtl/core/risc_instruction_execute.sv]
// ---------------------------------------------------------------------------
// risc_instruction_execute
// Executes one instruction of a sixteen-register RISC core per transfer.
// ---------------------------------------------------------------------------
//  Channel  Direction  Content
//  s_axis   in         instruction word and the word that follows it
//  m_axis   out        next PC, halt, register, store and I/O write report
//
//  An instruction is read from the register file at its transfer, executes
//  in the execute stage and finishes its load data in the load stage; the
//  result is then held in the output register until it is taken. One
//  instruction per cycle is sustained while the output is not stalled,
//  with forwarding covering back-to-back dependences.
//  After reset the data memory is cleared one word per cycle, and no
//  input is taken during that clearing pass. A stalled output stalls the
//  pipeline stage by stage.
// ---------------------------------------------------------------------------
module risc_instruction_execute #(
  parameter int DATA_WORDS   = 4096,
  parameter int INSTR_WORDS  = 1024,
  parameter int IO_REG_COUNT = 22
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // instruction_word [19:0], immediate_word [39:20]
  input  logic [rie_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // next_pc [9:0], halted [10], used_immediate [11], reg_written [12],
  // written_reg [16:13], written_value [48:17], mem_written [49],
  // mem_address [61:50], store_value [93:62], io_written [94],
  // io_index [99:95], zero fill [103:100]
  output logic [rie_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

  localparam int DAW = $clog2(DATA_WORDS);
  localparam int IOW = $clog2(IO_REG_COUNT);
  localparam int W   = rie_pkg::WORD_W;
  localparam int RW  = rie_pkg::RIDX_W;
  localparam int PW  = rie_pkg::PC_W;

  // Handshake and pipeline control.
  logic in_fire;
  logic x_fire;
  logic m_fire;
  logic x_valid_q;
  logic m_valid_q;
  logic out_valid_q;

  // Data memory clearing pass.
  logic           clr_busy_q;
  logic [DAW-1:0] clr_cnt_q;

  // Architectural state held in flops.
  logic [PW-1:0]  pc_q;
  logic           halt_q;
  logic [W-1:0]   r1_q;
  logic [W-1:0]   io_q [IO_REG_COUNT];
  logic [rie_pkg::REG_COUNT-1:0] rf_vld_q;

  // Register file, two copies with one shared write port.
  logic [W-1:0]   rf_a_mem [rie_pkg::REG_COUNT];
  logic [W-1:0]   rf_b_mem [rie_pkg::REG_COUNT];
  logic           rf_we;
  logic [RW-1:0]  rf_waddr;
  logic [W-1:0]   rf_wdata;

  // Latest register file write, for reads that overlap it.
  logic           wb_vld_q;
  logic [RW-1:0]  wb_idx_q;
  logic [W-1:0]   wb_val_q;

  // Data memory.
  logic [W-1:0]   dm_mem [DATA_WORDS];
  logic [W-1:0]   dm_rdata_q;
  logic           dm_we;
  logic [DAW-1:0] dm_waddr;
  logic [W-1:0]   dm_wdata;

  // Execute stage registers.
  logic [rie_pkg::INSTR_W-1:0] x_instr_q;
  logic [rie_pkg::INSTR_W-1:0] x_immw_q;
  logic [W-1:0]   x_rs_raw_q;
  logic [W-1:0]   x_rt_raw_q;
  logic [W-1:0]   x_rd_raw_q;
  logic           x_rs_vld_q;
  logic           x_rt_vld_q;
  logic           x_rd_vld_q;

  // Execute stage decode and results.
  logic [7:0]     x_opc;
  logic           x_illegal;
  rie_pkg::op_e   x_op;
  logic [RW-1:0]  x_rd;
  logic [RW-1:0]  x_rs;
  logic [RW-1:0]  x_rt;
  logic           x_imm;
  logic [W-1:0]   x_imm_val;
  logic [W-1:0]   x_r1;
  logic [W-1:0]   x_a;
  logic [W-1:0]   x_b;
  logic [W-1:0]   x_c;
  logic [W-1:0]   x_addr;
  logic           x_dm_ok;
  logic           x_io_ok;
  logic [W-1:0]   x_io_rdata;
  logic [W-1:0]   x_seq_w;
  logic [PW-1:0]  x_seq;
  logic [PW-1:0]  x_tgt_src;
  logic [PW-1:0]  x_tgt;
  rie_pkg::alu_out_t x_alu;
  logic [PW-1:0]  x_npc;
  logic           x_halt_set;
  logic           x_wr;
  logic [RW-1:0]  x_widx;
  logic [W-1:0]   x_val;
  logic           x_load;
  logic           x_dm_we;
  logic           x_io_we;
  logic [W-1:0]   x_store;
  rie_pkg::res_t  x_res;

  // Load stage and output registers.
  rie_pkg::res_t  m_res_q;
  logic           m_load_q;
  rie_pkg::res_t  m_res;
  rie_pkg::res_t  out_res_q;

  // Operand selection: fixed registers, then the newest pending write.
  function automatic logic [W-1:0] pick_opnd(
    input logic [RW-1:0] idx,
    input logic [W-1:0]  raw,
    input logic          vld,
    input logic [W-1:0]  r1v,
    input logic          m_hit,
    input logic [RW-1:0] m_idx,
    input logic [W-1:0]  m_val,
    input logic          wb_hit,
    input logic [RW-1:0] wb_idx,
    input logic [W-1:0]  wb_val
  );
    logic [W-1:0] v;
    if (idx == rie_pkg::R0_IDX) begin
      v = '0;
    end else if (idx == rie_pkg::R1_IDX) begin
      v = r1v;
    end else if (m_hit && (m_idx == idx)) begin
      v = m_val;
    end else if (wb_hit && (wb_idx == idx)) begin
      v = wb_val;
    end else if (vld) begin
      v = raw;
    end else begin
      v = '0;
    end
    return v;
  endfunction

  // Jump target modulo the instruction memory size by conditional subtracts.
  function automatic logic [PW-1:0] wrap_tgt(input logic [PW-1:0] t);
    logic [31:0] r;
    r = 32'(t);
    for (int k = rie_pkg::TGT_STEPS - 1; k >= 0; k--) begin
      if (r >= (32'(INSTR_WORDS) << k)) begin
        r = r - (32'(INSTR_WORDS) << k);
      end
    end
    return r[PW-1:0];
  endfunction

  // Pipeline handshakes.
  assign m_fire        = m_valid_q && (!out_valid_q || m_axis_tready);
  assign x_fire        = x_valid_q && (!m_valid_q || m_fire);
  assign s_axis_tready = !clr_busy_q && (!x_valid_q || x_fire);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Stage valid flags and the clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_valid_q   <= 1'b0;
      m_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      clr_busy_q  <= 1'b1;
      clr_cnt_q   <= '0;
    end else begin
      if (in_fire) begin
        x_valid_q <= 1'b1;
      end else if (x_fire) begin
        x_valid_q <= 1'b0;
      end
      if (x_fire) begin
        m_valid_q <= 1'b1;
      end else if (m_fire) begin
        m_valid_q <= 1'b0;
      end
      if (m_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (clr_busy_q) begin
        if (clr_cnt_q == DAW'(DATA_WORDS - 1)) begin
          clr_busy_q <= 1'b0;
        end else begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
        end
      end
    end
  end

  // Register file: write at the end of the load stage, read at input transfer.
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_a_mem[rf_waddr] <= rf_wdata;
      rf_b_mem[rf_waddr] <= rf_wdata;
    end
    if (in_fire) begin
      x_rs_raw_q <= rf_a_mem[s_axis_tdata[7:4]];
      x_rd_raw_q <= rf_a_mem[s_axis_tdata[11:8]];
      x_rt_raw_q <= rf_b_mem[s_axis_tdata[3:0]];
    end
  end

  // Execute stage payload and the valid bits sampled with the read.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_instr_q  <= s_axis_tdata[19:0];
      x_immw_q   <= s_axis_tdata[39:20];
      x_rs_vld_q <= rf_vld_q[s_axis_tdata[7:4]];
      x_rt_vld_q <= rf_vld_q[s_axis_tdata[3:0]];
      x_rd_vld_q <= rf_vld_q[s_axis_tdata[11:8]];
    end
  end

  // Decode, with illegal forms turned into a nop.
  always_comb begin
    x_opc     = x_instr_q[19:12];
    x_illegal = (x_opc > rie_pkg::OP_HALT) ||
                (((x_opc < rie_pkg::OP_BEQ) || (x_opc == rie_pkg::OP_LW) ||
                  (x_opc == rie_pkg::OP_IN)) && (x_instr_q[11:8] == rie_pkg::R1_IDX));
    x_op      = x_illegal ? rie_pkg::OP_ADD : rie_pkg::op_e'(x_opc);
    x_rd      = x_illegal ? rie_pkg::R0_IDX : x_instr_q[11:8];
    x_rs      = x_illegal ? rie_pkg::R0_IDX : x_instr_q[7:4];
    x_rt      = x_illegal ? rie_pkg::R0_IDX : x_instr_q[3:0];
    x_imm     = (x_rd == rie_pkg::R1_IDX) || (x_rs == rie_pkg::R1_IDX) ||
                (x_rt == rie_pkg::R1_IDX);
    x_imm_val = {{(W - rie_pkg::INSTR_W){x_immw_q[rie_pkg::IMM_SIGN_BIT]}}, x_immw_q};
    x_r1      = x_imm ? x_imm_val : r1_q;
  end

  // Load stage result, with load data merged in when a register is written.
  always_comb begin
    m_res = m_res_q;
    if (m_load_q && m_res_q.reg_written) begin
      m_res.written_value = dm_rdata_q;
    end
  end

  // Operands with forwarding from the load stage and the latest write.
  assign x_a = pick_opnd(x_rs, x_rs_raw_q, x_rs_vld_q, x_r1,
                         m_valid_q && m_res_q.reg_written, m_res_q.written_reg,
                         m_res.written_value, wb_vld_q, wb_idx_q, wb_val_q);
  assign x_b = pick_opnd(x_rt, x_rt_raw_q, x_rt_vld_q, x_r1,
                         m_valid_q && m_res_q.reg_written, m_res_q.written_reg,
                         m_res.written_value, wb_vld_q, wb_idx_q, wb_val_q);
  assign x_c = pick_opnd(x_rd, x_rd_raw_q, x_rd_vld_q, x_r1,
                         m_valid_q && m_res_q.reg_written, m_res_q.written_reg,
                         m_res.written_value, wb_vld_q, wb_idx_q, wb_val_q);

  rie_alu u_alu (
    .op_i  (x_op),
    .a_i   (x_a),
    .b_i   (x_b),
    .res_o (x_alu)
  );

  // Addresses, sequential PC and jump target.
  always_comb begin
    x_addr     = x_a + x_b;
    x_dm_ok    = (x_addr < 32'(DATA_WORDS));
    x_io_ok    = (x_addr < 32'(IO_REG_COUNT));
    x_io_rdata = x_io_ok ? io_q[x_addr[IOW-1:0]] : '0;
    x_seq_w    = 32'(pc_q) + (x_imm ? 32'd2 : 32'd1);
    if (x_seq_w >= 32'(INSTR_WORDS)) begin
      x_seq_w = x_seq_w - 32'(INSTR_WORDS);
    end
    x_seq = x_seq_w[PW-1:0];
    if (x_op == rie_pkg::OP_RETI) begin
      x_tgt_src = io_q[rie_pkg::RETI_IO_IDX][PW-1:0];
    end else if ((x_op == rie_pkg::OP_JAL) && (x_rd == rie_pkg::LINK_IDX)) begin
      x_tgt_src = x_seq;
    end else begin
      x_tgt_src = x_c[PW-1:0];
    end
    x_tgt = wrap_tgt(x_tgt_src);
  end

  // Operation effects.
  always_comb begin
    x_npc      = x_seq;
    x_halt_set = 1'b0;
    x_wr       = 1'b0;
    x_widx     = x_rd;
    x_val      = x_alu.val;
    x_load     = 1'b0;
    x_dm_we    = 1'b0;
    x_io_we    = 1'b0;
    x_store    = x_c;
    case (x_op)
      rie_pkg::OP_ADD, rie_pkg::OP_SUB, rie_pkg::OP_AND, rie_pkg::OP_OR,
      rie_pkg::OP_XOR, rie_pkg::OP_MUL, rie_pkg::OP_SLL, rie_pkg::OP_SRA,
      rie_pkg::OP_SRL: begin
        x_wr = 1'b1;
      end
      rie_pkg::OP_BEQ, rie_pkg::OP_BNE, rie_pkg::OP_BLT, rie_pkg::OP_BGT,
      rie_pkg::OP_BLE, rie_pkg::OP_BGE: begin
        if (x_alu.taken) begin
          x_npc = x_tgt;
        end
      end
      rie_pkg::OP_JAL: begin
        x_wr   = 1'b1;
        x_widx = rie_pkg::LINK_IDX;
        x_val  = W'(x_seq);
        x_npc  = x_tgt;
      end
      rie_pkg::OP_LW: begin
        x_wr   = x_dm_ok;
        x_load = x_dm_ok;
        x_val  = '0;
      end
      rie_pkg::OP_SW: begin
        x_dm_we = x_dm_ok;
      end
      rie_pkg::OP_RETI: begin
        x_npc = x_tgt;
      end
      rie_pkg::OP_IN: begin
        x_wr  = x_io_ok;
        x_val = x_io_rdata;
      end
      rie_pkg::OP_OUT: begin
        x_io_we = x_io_ok;
      end
      rie_pkg::OP_HALT: begin
        x_halt_set = 1'b1;
        x_npc      = pc_q;
      end
      default: begin
        x_npc = x_seq;
      end
    endcase
    // A halted core reports its held PC and does nothing else.
    if (halt_q) begin
      x_npc   = pc_q;
      x_wr    = 1'b0;
      x_load  = 1'b0;
      x_dm_we = 1'b0;
      x_io_we = 1'b0;
    end
  end

  // Assemble the result item of the execute stage.
  always_comb begin
    x_res                = '0;
    x_res.next_pc        = x_npc;
    x_res.halted         = halt_q || x_halt_set;
    x_res.used_immediate = x_imm && !halt_q;
    if (x_wr && (x_widx != rie_pkg::R0_IDX)) begin
      x_res.reg_written   = 1'b1;
      x_res.written_reg   = x_widx;
      x_res.written_value = x_val;
    end
    if (x_dm_we) begin
      x_res.mem_written = 1'b1;
      x_res.mem_address = x_addr[11:0];
      x_res.store_value = x_store;
    end
    if (x_io_we) begin
      x_res.io_written  = 1'b1;
      x_res.io_index    = x_addr[4:0];
      x_res.store_value = x_store;
    end
  end

  // Architectural flops set at execute; write tracking at load completion.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= '0;
      halt_q   <= 1'b0;
      r1_q     <= '0;
      rf_vld_q <= '0;
      wb_vld_q <= 1'b0;
      wb_idx_q <= '0;
      wb_val_q <= '0;
      for (int i = 0; i < IO_REG_COUNT; i++) begin
        io_q[i] <= '0;
      end
    end else begin
      if (x_fire && !halt_q) begin
        pc_q   <= x_npc;
        halt_q <= x_halt_set;
        if (x_imm) begin
          r1_q <= x_imm_val;
        end
        if (x_io_we) begin
          io_q[x_addr[IOW-1:0]] <= x_store;
        end
      end
      if (rf_we) begin
        rf_vld_q[rf_waddr] <= 1'b1;
        wb_vld_q           <= 1'b1;
        wb_idx_q           <= rf_waddr;
        wb_val_q           <= rf_wdata;
      end
    end
  end

  // Data memory: clearing pass, store, and load read.
  assign dm_we    = clr_busy_q || (x_fire && x_dm_we);
  assign dm_waddr = clr_busy_q ? clr_cnt_q : x_addr[DAW-1:0];
  assign dm_wdata = clr_busy_q ? '0 : x_store;

  always_ff @(posedge clk_i) begin
    if (dm_we) begin
      dm_mem[dm_waddr] <= dm_wdata;
    end
    if (x_fire && x_load) begin
      dm_rdata_q <= dm_mem[x_addr[DAW-1:0]];
    end
  end

  // Load stage payload.
  always_ff @(posedge clk_i) begin
    if (x_fire) begin
      m_res_q  <= x_res;
      m_load_q <= x_load;
    end
  end

  // Register file write port.
  assign rf_we    = m_fire && m_res_q.reg_written;
  assign rf_waddr = m_res_q.written_reg;
  assign rf_wdata = m_res.written_value;

  // Output register.
  always_ff @(posedge clk_i) begin
    if (m_fire) begin
      out_res_q <= m_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{rie_pkg::M_PAD_W{1'b0}}, out_res_q};

  // Assertions.
  `include "risc_instruction_execute_assert.svh"

  `RIE_ASSERT_NXT(a_halt_sticky, clk_i, rst_ni, halt_q, halt_q, "halt flag cleared")
  `RIE_ASSERT_IMP(a_fixed_regs, clk_i, rst_ni, rf_we, (rf_waddr != rie_pkg::R0_IDX) && (rf_waddr != rie_pkg::R1_IDX), "r0 or r1 written through the register file")
  `RIE_ASSERT_IMP(a_pc_range, clk_i, rst_ni, 1'b1, 32'(pc_q) < 32'(INSTR_WORDS), "PC beyond instruction memory")
  `RIE_ASSERT_IMP(a_halt_quiet, clk_i, rst_ni, m_axis_tvalid && out_res_q.halted, !out_res_q.reg_written && !out_res_q.mem_written && !out_res_q.io_written, "halted result reports a write")

endmodule

[rtl/core/rie_alu.sv]
// ---------------------------------------------------------------------------
// rie_alu
// Arithmetic, logic and shift unit with the signed branch comparator.
// ---------------------------------------------------------------------------
module rie_alu (
  input  rie_pkg::op_e                  op_i,
  input  logic [rie_pkg::WORD_W-1:0]    a_i,
  input  logic [rie_pkg::WORD_W-1:0]    b_i,
  output rie_pkg::alu_out_t             res_o
);

  logic [4:0] sh;

  assign sh = b_i[4:0];

  always_comb begin
    res_o = '0;
    // Data result of the register-to-register operations.
    case (op_i)
      rie_pkg::OP_ADD: res_o.val = a_i + b_i;
      rie_pkg::OP_SUB: res_o.val = a_i - b_i;
      rie_pkg::OP_AND: res_o.val = a_i & b_i;
      rie_pkg::OP_OR:  res_o.val = a_i | b_i;
      rie_pkg::OP_XOR: res_o.val = a_i ^ b_i;
      rie_pkg::OP_MUL: res_o.val = a_i * b_i;
      rie_pkg::OP_SLL: res_o.val = a_i << sh;
      rie_pkg::OP_SRA: res_o.val = $unsigned($signed(a_i) >>> sh);
      rie_pkg::OP_SRL: res_o.val = a_i >> sh;
      default:         res_o.val = '0;
    endcase
    // Branch condition; all comparisons are signed.
    case (op_i)
      rie_pkg::OP_BEQ: res_o.taken = (a_i == b_i);
      rie_pkg::OP_BNE: res_o.taken = (a_i != b_i);
      rie_pkg::OP_BLT: res_o.taken = ($signed(a_i) < $signed(b_i));
      rie_pkg::OP_BGT: res_o.taken = ($signed(a_i) > $signed(b_i));
      rie_pkg::OP_BLE: res_o.taken = ($signed(a_i) <= $signed(b_i));
      rie_pkg::OP_BGE: res_o.taken = ($signed(a_i) >= $signed(b_i));
      default:         res_o.taken = 1'b0;
    endcase
  end

endmodule
